// ===== rtl/core/bve_pkg.sv =====
// Shared types, operation codes and microcode field codes for the bounded vector engine.
// No dependencies; every other file in rtl/core imports this package.
package bve_pkg;

   // Fixed field widths of the request and response words.
   localparam int OP_W          = 3;
   localparam int VALUE_W       = 32;
   localparam int IDX_W         = 8;
   localparam int CNT_OUT_W     = 9;
   localparam int STEP_W        = 4;
   localparam int DEFAULT_DEPTH = 256;

   typedef logic [OP_W-1:0]   op_type;
   typedef logic [STEP_W-1:0] step_type;
   typedef logic [3:0]        act_type;
   typedef logic [2:0]        cond_type;

   // Request operation codes.
   localparam op_type OP_PUSH   = 3'd0;
   localparam op_type OP_POP    = 3'd1;
   localparam op_type OP_CLEAR  = 3'd2;
   localparam op_type OP_ERASE  = 3'd3;
   localparam op_type OP_DELVAL = 3'd4;
   localparam op_type OP_GET    = 3'd5;

   // Datapath actions carried in each control word.
   localparam act_type ACT_NONE        = 4'd0;
   localparam act_type ACT_PUSH        = 4'd1;
   localparam act_type ACT_POP         = 4'd2;
   localparam act_type ACT_CLEAR       = 4'd3;
   localparam act_type ACT_INIT_ERASE  = 4'd4;
   localparam act_type ACT_INIT_DELVAL = 4'd5;
   localparam act_type ACT_COMPACT     = 4'd6;
   localparam act_type ACT_SET_COUNT   = 4'd7;
   localparam act_type ACT_READ_IDX    = 4'd8;
   localparam act_type ACT_CAPTURE     = 4'd9;

   // Jump conditions; when the condition is false the step counter advances by one.
   localparam cond_type COND_NEXT     = 3'd0;
   localparam cond_type COND_ALWAYS   = 3'd1;
   localparam cond_type COND_NO_START = 3'd2;
   localparam cond_type COND_FULL     = 3'd3;
   localparam cond_type COND_EMPTY    = 3'd4;
   localparam cond_type COND_IDX_BAD  = 3'd5;
   localparam cond_type COND_LOOP     = 3'd6;
   localparam cond_type COND_DISPATCH = 3'd7;

   // Part of the control word that drives the datapath.
   typedef struct packed {
      act_type act;
      logic    finish;
      logic    ok;
   } ctrl_type;

   // One full microcode word.
   typedef struct packed {
      ctrl_type ctrl;
      cond_type cond;
      step_type target;
   } ucode_type;

   // Status flags that the sequencer tests for its jumps.
   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   idx_bad;
      logic   loop_more;
   } status_type;

endpackage

// ===== rtl/core/bve_seq.sv =====
// Microcode sequencer: step counter, control-word ROM and jump logic.
// Depends on bve_pkg for the control word, status and code definitions.
module bve_seq
   import bve_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output logic       busy,
   output ctrl_type   ctrl
);

   // Step addresses of the microprogram.
   localparam step_type ST_IDLE        = 4'd0;
   localparam step_type ST_DISPATCH    = 4'd1;
   localparam step_type ST_PUSH_CHK    = 4'd2;
   localparam step_type ST_PUSH_DO     = 4'd3;
   localparam step_type ST_POP_CHK     = 4'd4;
   localparam step_type ST_POP_DO      = 4'd5;
   localparam step_type ST_CLEAR       = 4'd6;
   localparam step_type ST_ERASE_CHK   = 4'd7;
   localparam step_type ST_ERASE_INIT  = 4'd8;
   localparam step_type ST_DELVAL_INIT = 4'd9;
   localparam step_type ST_COMPACT     = 4'd10;
   localparam step_type ST_COMPACT_END = 4'd11;
   localparam step_type ST_GET_CHK     = 4'd12;
   localparam step_type ST_GET_READ    = 4'd13;
   localparam step_type ST_GET_DONE    = 4'd14;
   localparam step_type ST_FAIL        = 4'd15;

   step_type  step_ff, step_in;
   ucode_type uword;
   step_type  jump_target;
   logic      jump_hit;

   // Control store: one word per step.
   always_comb begin
      uword = '{ctrl: '{act: ACT_NONE, finish: 1'b0, ok: 1'b0},
                cond: COND_NEXT, target: ST_IDLE};
      unique case (step_ff)
         ST_IDLE: begin
            uword.cond   = COND_NO_START;
            uword.target = ST_IDLE;
         end
         ST_DISPATCH: begin
            uword.cond = COND_DISPATCH;
         end
         ST_PUSH_CHK: begin
            uword.cond   = COND_FULL;
            uword.target = ST_FAIL;
         end
         ST_PUSH_DO: begin
            uword.ctrl = '{act: ACT_PUSH, finish: 1'b1, ok: 1'b1};
            uword.cond = COND_ALWAYS;
         end
         ST_POP_CHK: begin
            uword.cond   = COND_EMPTY;
            uword.target = ST_FAIL;
         end
         ST_POP_DO: begin
            uword.ctrl = '{act: ACT_POP, finish: 1'b1, ok: 1'b1};
            uword.cond = COND_ALWAYS;
         end
         ST_CLEAR: begin
            uword.ctrl = '{act: ACT_CLEAR, finish: 1'b1, ok: 1'b1};
            uword.cond = COND_ALWAYS;
         end
         ST_ERASE_CHK: begin
            uword.cond   = COND_IDX_BAD;
            uword.target = ST_FAIL;
         end
         ST_ERASE_INIT: begin
            uword.ctrl.act = ACT_INIT_ERASE;
            uword.cond     = COND_ALWAYS;
            uword.target   = ST_COMPACT;
         end
         ST_DELVAL_INIT: begin
            uword.ctrl.act = ACT_INIT_DELVAL;
         end
         ST_COMPACT: begin
            uword.ctrl.act = ACT_COMPACT;
            uword.cond     = COND_LOOP;
            uword.target   = ST_COMPACT;
         end
         ST_COMPACT_END: begin
            uword.ctrl = '{act: ACT_SET_COUNT, finish: 1'b1, ok: 1'b1};
            uword.cond = COND_ALWAYS;
         end
         ST_GET_CHK: begin
            uword.cond   = COND_IDX_BAD;
            uword.target = ST_FAIL;
         end
         ST_GET_READ: begin
            uword.ctrl.act = ACT_READ_IDX;
         end
         ST_GET_DONE: begin
            uword.ctrl = '{act: ACT_CAPTURE, finish: 1'b1, ok: 1'b1};
            uword.cond = COND_ALWAYS;
         end
         ST_FAIL: begin
            uword.ctrl = '{act: ACT_NONE, finish: 1'b1, ok: 1'b0};
            uword.cond = COND_ALWAYS;
         end
         default: ;
      endcase
   end

   // Entry point of each operation's routine; unused codes report a failure.
   always_comb begin
      jump_target = uword.target;
      if (uword.cond == COND_DISPATCH) begin
         unique case (status.op)
            OP_PUSH:   jump_target = ST_PUSH_CHK;
            OP_POP:    jump_target = ST_POP_CHK;
            OP_CLEAR:  jump_target = ST_CLEAR;
            OP_ERASE:  jump_target = ST_ERASE_CHK;
            OP_DELVAL: jump_target = ST_DELVAL_INIT;
            OP_GET:    jump_target = ST_GET_CHK;
            default:   jump_target = ST_FAIL;
         endcase
      end
   end

   // Jump condition select.
   always_comb begin
      unique case (uword.cond)
         COND_NEXT:     jump_hit = 1'b0;
         COND_ALWAYS:   jump_hit = 1'b1;
         COND_NO_START: jump_hit = !start;
         COND_FULL:     jump_hit = status.full;
         COND_EMPTY:    jump_hit = status.empty;
         COND_IDX_BAD:  jump_hit = status.idx_bad;
         COND_LOOP:     jump_hit = status.loop_more;
         COND_DISPATCH: jump_hit = 1'b1;
         default:       jump_hit = 1'b0;
      endcase
   end

   assign step_in = jump_hit ? jump_target : step_ff + STEP_W'(1);

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign busy = (step_ff != ST_IDLE);
   assign ctrl = uword.ctrl;

endmodule

// ===== rtl/core/bve_datapath.sv =====
// Datapath: entry memory, fill count, compaction pointers and response registers.
// Depends on bve_pkg; driven by control words from bve_seq.
module bve_datapath
   import bve_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [VALUE_W-1:0]   req_value,
   input  logic [IDX_W-1:0]     req_index,
   input  ctrl_type             ctrl,
   output status_type           status,
   output logic                 rsp_strobe,
   output logic                 rsp_ok,
   output logic [VALUE_W-1:0]   rsp_read_value,
   output logic [CNT_OUT_W-1:0] rsp_removed_count,
   output logic [CNT_OUT_W-1:0] rsp_fill_count
);

   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int IXW = (CW > IDX_W) ? CW : IDX_W;
   localparam int OW  = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

   logic [VALUE_W-1:0] mem [DEPTH];

   // Latched request word.
   op_type             op_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [IDX_W-1:0]   idx_ff;

   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]      pend_addr_ff, pend_addr_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [CW-1:0]      removed_ff, removed_in;
   logic [VALUE_W-1:0] rdata_ff;

   logic               rsp_strobe_ff;
   logic               rsp_ok_ff;
   logic [VALUE_W-1:0] rsp_read_ff;
   logic [CNT_OUT_W-1:0] rsp_removed_ff;
   logic [CNT_OUT_W-1:0] rsp_fill_ff;

   logic               we;
   logic [AW-1:0]      waddr;
   logic [VALUE_W-1:0] wdata;
   logic [AW-1:0]      raddr;

   logic [IXW-1:0]     idx_wide;
   logic [IXW-1:0]     count_wide;
   logic [CW-1:0]      idx_cnt;
   logic               erase_mode;
   logic               keep;
   logic               more_to_read;
   logic [OW-1:0]      removed_wide;
   logic [OW-1:0]      fill_wide;

   assign idx_wide     = IXW'(idx_ff);
   assign count_wide   = IXW'(count_ff);
   assign idx_cnt      = idx_wide[CW-1:0];
   assign erase_mode   = (op_ff == OP_ERASE);
   assign more_to_read = (rd_ptr_ff < count_ff);

   // Erase drops only the entry at the index; delete-value drops every match.
   assign keep = erase_mode ? (IXW'(pend_addr_ff) != idx_wide) : (rdata_ff != value_ff);

   // Status for the sequencer's jumps.
   assign status.op        = op_ff;
   assign status.full      = (count_ff == CW'(DEPTH));
   assign status.empty     = (count_ff == '0);
   assign status.idx_bad   = (idx_wide >= count_wide);
   assign status.loop_more = more_to_read || pend_valid_ff;

   // Next-state logic for the count, pointers and memory port controls.
   always_comb begin
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      pend_addr_in  = pend_addr_ff;
      pend_valid_in = pend_valid_ff;
      removed_in    = removed_ff;
      we            = 1'b0;
      waddr         = count_ff[AW-1:0];
      wdata         = value_ff;
      raddr         = rd_ptr_ff[AW-1:0];
      if (accept) begin
         removed_in = '0;
      end
      unique case (ctrl.act)
         ACT_PUSH: begin
            we       = 1'b1;
            count_in = count_ff + CW'(1);
         end
         ACT_POP: begin
            count_in = count_ff - CW'(1);
         end
         ACT_CLEAR: begin
            count_in = '0;
         end
         ACT_INIT_ERASE: begin
            rd_ptr_in     = idx_cnt;
            wr_ptr_in     = idx_cnt;
            pend_valid_in = 1'b0;
         end
         ACT_INIT_DELVAL: begin
            rd_ptr_in     = '0;
            wr_ptr_in     = '0;
            pend_valid_in = 1'b0;
         end
         ACT_COMPACT: begin
            // Retire the word read last cycle, then issue the next read.
            if (pend_valid_ff) begin
               if (keep) begin
                  we        = 1'b1;
                  waddr     = wr_ptr_ff[AW-1:0];
                  wdata     = rdata_ff;
                  wr_ptr_in = wr_ptr_ff + CW'(1);
               end else if (!erase_mode) begin
                  removed_in = removed_ff + CW'(1);
               end
            end
            if (more_to_read) begin
               pend_valid_in = 1'b1;
               pend_addr_in  = rd_ptr_ff;
               rd_ptr_in     = rd_ptr_ff + CW'(1);
            end else begin
               pend_valid_in = 1'b0;
            end
         end
         ACT_SET_COUNT: begin
            count_in = wr_ptr_ff;
         end
         ACT_READ_IDX: begin
            raddr = idx_cnt[AW-1:0];
         end
         default: ;
      endcase
   end

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   // Request capture on acceptance.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_operation;
         value_ff <= req_value;
         idx_ff   <= req_index;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         removed_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         removed_ff    <= removed_in;
         rsp_strobe_ff <= ctrl.finish;
      end
   end

   // Pointers.
   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      wr_ptr_ff    <= wr_ptr_in;
      pend_addr_ff <= pend_addr_in;
   end

   assign removed_wide = OW'(removed_ff);
   assign fill_wide    = OW'(count_in);

   // Response word, loaded on the finishing step.
   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         rsp_ok_ff      <= ctrl.ok;
         rsp_read_ff    <= (ctrl.act == ACT_CAPTURE) ? rdata_ff : '0;
         rsp_removed_ff <= removed_wide[CNT_OUT_W-1:0];
         rsp_fill_ff    <= fill_wide[CNT_OUT_W-1:0];
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_read_value    = rsp_read_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_fill_count    = rsp_fill_ff;

   // The fill count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count exceeds capacity");

   // Compaction never writes ahead of where it reads.
   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (ctrl.act == ACT_COMPACT) |-> (wr_ptr_ff <= rd_ptr_ff))
      else $error("compaction write pointer passed read pointer");

   // A push grows the list by exactly one word.
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (ctrl.act == ACT_PUSH) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("push did not advance the fill count");

endmodule

// ===== rtl/core/bounded_vector_engine.sv =====
// Top level of the bounded vector engine: microcode sequencer plus datapath.
// Depends on bve_pkg, bve_seq and bve_datapath.
//
//   Channel   Ports                                      Handshake
//   request   req_operation, req_value, req_index        start high while busy low
//   response  rsp_ok, rsp_read_value, rsp_removed_count,  rsp_strobe, one cycle
//             rsp_fill_count
//
// The strobe follows the finishing step of each operation's routine. A refused push, pop, erase
// or get and an unused code end in the failure step; a get in range first reads the entry. Erase
// and delete-value walk the entries through the entry memory, one per cycle, then set the count.
// Busy is already low when the strobe rises, so the next word can be taken in that cycle.
// Reset empties the list at once; the entry memory itself is not cleared.
// The receiver cannot stall: the strobe is high for a single cycle, and the response word holds until the next one.
module bounded_vector_engine
   import bve_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [OP_W-1:0]             req_operation,
   input  logic signed [VALUE_W-1:0]   req_value,
   input  logic [IDX_W-1:0]            req_index,
   output logic                        rsp_strobe,
   output logic                        rsp_ok,
   output logic signed [VALUE_W-1:0]   rsp_read_value,
   output logic [CNT_OUT_W-1:0]        rsp_removed_count,
   output logic [CNT_OUT_W-1:0]        rsp_fill_count
);

   ctrl_type           ctrl;
   status_type         status;
   logic               accept;
   logic [VALUE_W-1:0] read_value;

   assign accept = start && !busy;

   // Program sequencer.
   bve_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .ctrl   (ctrl)
   );

   // Storage and arithmetic.
   bve_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_operation     (req_operation),
      .req_value         (req_value),
      .req_index         (req_index),
      .ctrl              (ctrl),
      .status            (status),
      .rsp_strobe        (rsp_strobe),
      .rsp_ok            (rsp_ok),
      .rsp_read_value    (read_value),
      .rsp_removed_count (rsp_removed_count),
      .rsp_fill_count    (rsp_fill_count)
   );

   assign rsp_read_value = read_value;

endmodule
